// ===== hdl/wall_switch_frame_recognizer_unit_assert.svh =====
// Assertion macros for the wall switch frame recognizer.
`ifndef WALL_SWITCH_FRAME_RECOGNIZER_UNIT_ASSERT_SVH
`define WALL_SWITCH_FRAME_RECOGNIZER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define WSFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsfr assertion failed");

// Next-cycle implication, clocked on clk, held off during reset.
`define WSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsfr assertion failed");

`endif

// ===== hdl/wsfr_pkg.sv =====
// Package with types and codes of the wall switch frame recognizer.
package wsfr_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t [7:0] frame_t;

  localparam int unsigned FRAME_BYTES = 8;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_GAP  = 1'b1;

  localparam logic REG_ID_FIRST  = 1'b0;
  localparam logic REG_ID_SECOND = 1'b1;

  localparam byte_t HDR_INDIV_VAL  = 8'h30;
  localparam byte_t HDR_INDIV_MASK = 8'hF0;
  localparam byte_t HDR_ALL        = 8'hFF;
  localparam byte_t HDR_STATUS     = 8'h50;
  localparam byte_t CH_EQ          = 8'h3D;
  localparam byte_t CH_O           = 8'h4F;
  localparam byte_t CH_L           = 8'h4C;
  localparam byte_t CH_BANG        = 8'h21;
  localparam byte_t CH_CR          = 8'h0D;
  localparam byte_t CH_ZERO        = 8'h30;
  localparam byte_t CH_ONE         = 8'h31;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_OK       = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_INDIV  = 2'd0,
    KIND_ALL    = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_ID     = 2'd3
  } kind_e;

  typedef struct packed {
    status_e status;
    kind_e   kind;
    byte_t   head;
    byte_t   device;
    byte_t   value;
  } result_t;

  function automatic logic is_indiv(byte_t b);
    return (b & HDR_INDIV_MASK) == HDR_INDIV_VAL;
  endfunction

endpackage

// ===== hdl/wsfr_chan_if.sv =====
// Request and result channel interfaces of the frame recognizer.
interface wsfr_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [1:0] frame_kind;
  logic [7:0] head_byte;
  logic [7:0] device_byte;
  logic [7:0] value_byte;

  modport source (output valid, output frame_status, output frame_kind,
                  output head_byte, output device_byte, output value_byte,
                  input ready);
  modport sink (input valid, input frame_status, input frame_kind,
                input head_byte, input device_byte, input value_byte,
                output ready);
endinterface

// ===== hdl/wsfr_step.sv =====
// Next-state and result logic for one request of the frame recognizer.
module wsfr_step #(
  parameter int unsigned BUF_DEPTH = 8
) (
  input  logic                          op,
  input  wsfr_pkg::byte_t               rx_byte,
  input  wsfr_pkg::frame_t              bytes,
  input  logic [$clog2(BUF_DEPTH)-1:0]  fill,
  input  wsfr_pkg::byte_t               id_first,
  input  wsfr_pkg::byte_t               id_second,
  output wsfr_pkg::frame_t              bytes_next,
  output logic [$clog2(BUF_DEPTH)-1:0]  fill_next,
  output wsfr_pkg::result_t             res
);

  localparam int unsigned CW = $clog2(BUF_DEPTH);

  wsfr_pkg::byte_t  h;
  wsfr_pkg::byte_t  nh;
  logic             restart;
  logic             clear;
  logic [CW-1:0]    fc_pre;
  logic [CW:0]      fc_inc;
  wsfr_pkg::frame_t nb;
  wsfr_pkg::byte_t  x_sum;
  wsfr_pkg::byte_t  a_sum;

  always_comb begin
    h = bytes[0];
    restart = 1'b0;
    unique case (fill)
      CW'(1): begin
        if (!wsfr_pkg::is_indiv(h) && h != wsfr_pkg::HDR_STATUS &&
            h != wsfr_pkg::HDR_ALL && h != id_first) restart = 1'b1;
      end
      CW'(2): begin
        if (bytes[1] != wsfr_pkg::CH_EQ && bytes[1] != wsfr_pkg::CH_O &&
            bytes[1] != id_second) restart = 1'b1;
      end
      CW'(3): begin
        if (wsfr_pkg::is_indiv(h)) begin
          if (bytes[2] != wsfr_pkg::CH_ZERO && bytes[2] != wsfr_pkg::CH_ONE)
            restart = 1'b1;
        end else if (h == wsfr_pkg::HDR_STATUS) begin
          if (bytes[2] != wsfr_pkg::CH_L) restart = 1'b1;
        end
      end
      CW'(4): begin
        if (wsfr_pkg::is_indiv(h) || h == wsfr_pkg::HDR_ALL) begin
          if (bytes[3] != wsfr_pkg::CH_BANG) restart = 1'b1;
        end else if (h == wsfr_pkg::HDR_STATUS) begin
          if (bytes[3] != wsfr_pkg::CH_L) restart = 1'b1;
        end
      end
      CW'(5): begin
        if (h == wsfr_pkg::HDR_STATUS && bytes[4] != wsfr_pkg::CH_BANG)
          restart = 1'b1;
      end
      default: restart = 1'b0;
    endcase

    fc_pre = restart ? '0 : fill;
    // Only the first eight positions are ever inspected; deeper bytes drop.
    nb = bytes;
    if ({1'b0, fc_pre} < (CW+1)'(wsfr_pkg::FRAME_BYTES)) nb[fc_pre[2:0]] = rx_byte;
    fc_inc = {1'b0, fc_pre} + (CW+1)'(1);

    x_sum = '0;
    for (int i = 0; i < 6; i++) x_sum = x_sum ^ nb[i];
    a_sum = '0;
    for (int i = 0; i < 7; i++) a_sum = a_sum + nb[i];

    res = '0;
    clear = 1'b0;
    nh = nb[0];
    if (nh == id_first && nb[1] == id_second) begin
      if (fc_inc >= (CW+1)'(wsfr_pkg::FRAME_BYTES)) begin
        res.status = (x_sum == nb[6] && a_sum == nb[7]) ? wsfr_pkg::STATUS_OK
                                                         : wsfr_pkg::STATUS_MISMATCH;
        res.kind   = wsfr_pkg::KIND_ID;
        res.head   = nb[0];
        res.device = nb[1];
        res.value  = nb[2];
        clear = 1'b1;
      end
    end else if (fc_inc >= (CW+1)'(BUF_DEPTH)) begin
      // Overflow of an unknown header: the head byte is cleared and the fill count restarts.
      clear = 1'b1;
    end else if (wsfr_pkg::is_indiv(nh) || nh == wsfr_pkg::HDR_ALL) begin
      if (fc_inc >= (CW+1)'(5)) begin
        if (nb[4] == wsfr_pkg::CH_CR) begin
          res.status = wsfr_pkg::STATUS_OK;
          res.kind   = wsfr_pkg::is_indiv(nh) ? wsfr_pkg::KIND_INDIV : wsfr_pkg::KIND_ALL;
          res.head   = nb[0];
          res.device = nb[1];
          res.value  = nb[2];
        end
        clear = 1'b1;
      end
    end else if (nh == wsfr_pkg::HDR_STATUS) begin
      if (fc_inc >= (CW+1)'(6)) begin
        if (nb[5] == wsfr_pkg::CH_CR) begin
          res.status = wsfr_pkg::STATUS_OK;
          res.kind   = wsfr_pkg::KIND_STATUS;
          res.head   = nb[0];
          res.device = nb[1];
          res.value  = nb[2];
        end
        clear = 1'b1;
      end
    end

    if (op == wsfr_pkg::OP_GAP) begin
      nb    = bytes;
      res   = '0;
      clear = 1'b1;
    end

    bytes_next = nb;
    if (clear) bytes_next[0] = '0;
    fill_next = clear ? '0 : fc_inc[CW-1:0];
  end

endmodule

// ===== hdl/wall_switch_frame_recognizer_unit.sv =====
// A request waits in the input register, and its result is held in the result register.
// Throughput: one request per cycle while the result sink takes results; while a result
//   waits, the input register holds one more request and then the request side stalls.
// Reset (rst, synchronous, active high): frame buffer, fill count, ID header
//   registers and all valid flags clear; no clearing pass is needed.
// Top level of the wall switch frame recognizer.
module wall_switch_frame_recognizer_unit #(
  parameter int unsigned BUF_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  wsfr_req_if.sink   req,
  wsfr_rsp_if.source rsp,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [7:0] wr_data
);

  localparam int unsigned CW = $clog2(BUF_DEPTH);

  // Configuration: ID frame header bytes.
  wsfr_pkg::byte_t id_first;
  wsfr_pkg::byte_t id_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_first  <= '0;
      id_second <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        wsfr_pkg::REG_ID_FIRST:  id_first  <= wr_data;
        wsfr_pkg::REG_ID_SECOND: id_second <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register: hold one request until the result register can take it.
  logic            s1_valid;
  logic            s1_op;
  wsfr_pkg::byte_t s1_byte;
  logic            advance;

  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op   <= req.op;
      s1_byte <= req.rx_byte;
    end
  end

  // Frame state: the first eight buffer positions and the fill count.
  wsfr_pkg::frame_t  frame_bytes;
  wsfr_pkg::frame_t  frame_bytes_next;
  logic [CW-1:0]     fill_count;
  logic [CW-1:0]     fill_count_next;
  wsfr_pkg::result_t step_res;

  wsfr_step #(.BUF_DEPTH(BUF_DEPTH)) u_step (
    .op         (s1_op),
    .rx_byte    (s1_byte),
    .bytes      (frame_bytes),
    .fill       (fill_count),
    .id_first   (id_first),
    .id_second  (id_second),
    .bytes_next (frame_bytes_next),
    .fill_next  (fill_count_next),
    .res        (step_res)
  );

  // Advance the frame state only when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= '0;
      fill_count  <= '0;
    end else if (advance) begin
      frame_bytes <= frame_bytes_next;
      fill_count  <= fill_count_next;
    end
  end

  // Result register: hold the result while the sink stalls.
  wsfr_pkg::result_t out_res;
  logic              out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_status = out_res.status;
  assign rsp.frame_kind   = out_res.kind;
  assign rsp.head_byte    = out_res.head;
  assign rsp.device_byte  = out_res.device;
  assign rsp.value_byte   = out_res.value;

`include "wall_switch_frame_recognizer_unit_assert.svh"

  // A gap timeout always leaves an empty buffer with a cleared head byte.
  `WSFR_ASSERT_NEXT(a_gap_clears, advance && s1_op == wsfr_pkg::OP_GAP, fill_count == '0 && frame_bytes[0] == '0)
  // The fill count never reaches the buffer depth.
  `WSFR_ASSERT_NOW(a_fill_bound, s1_valid, (CW+1)'(fill_count) < (CW+1)'(BUF_DEPTH))
  // A result with no frame carries all-zero fields.
  `WSFR_ASSERT_NOW(a_none_zero, out_valid && out_res.status == wsfr_pkg::STATUS_NONE, out_res.kind == wsfr_pkg::KIND_INDIV && out_res.head == '0 && out_res.device == '0 && out_res.value == '0)
  // A checksum mismatch is reported only for ID frames.
  `WSFR_ASSERT_NOW(a_mismatch_id, out_valid && out_res.status == wsfr_pkg::STATUS_MISMATCH, out_res.kind == wsfr_pkg::KIND_ID)

endmodule

// ===== test/tb_wall_switch_frame_recognizer_unit.sv =====
// Testbench of the wall switch frame recognizer: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_wall_switch_frame_recognizer_unit;

  // Frame lengths of the four kinds.
  localparam int unsigned CTRL_LEN   = 5;
  localparam int unsigned STATUS_LEN = 6;
  localparam int unsigned ID_LEN     = 8;

  // Chance in a hundred that a side idles in a given cycle.
  localparam int IDLE_PCT = 21;

  // Spoil position that leaves a frame intact.
  localparam int INTACT = -1;

  typedef struct packed {
    logic            op;
    wsfr_pkg::byte_t rx_byte;
  } request_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  logic       wr_index;
  logic [7:0] wr_data;

  wsfr_req_if req ();
  wsfr_rsp_if rsp ();

  wall_switch_frame_recognizer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block: frame buffer, fill count and the ID header pair.
  wsfr_pkg::byte_t frame_buf [wsfr_pkg::FRAME_BYTES];
  int unsigned     fill;
  wsfr_pkg::byte_t id_first;
  wsfr_pkg::byte_t id_second;

  request_t          pending_q [$];        // requests waiting for the driver
  wsfr_pkg::result_t expected_frames [$];  // predicted results, oldest first
  int                queued;               // requests queued in the current phase
  int                fail_count = 0;
  logic              req_taken = 1'b0;     // request handshake seen at the last rising edge
  logic              block_idle = 1'b0;    // nothing queued, in flight or outstanding
  logic              no_idle = 1'b0;       // hold both sides busy

  function automatic logic indiv_head(wsfr_pkg::byte_t b);
    return b[7:4] == wsfr_pkg::HDR_INDIV_VAL[7:4];
  endfunction

  function automatic void restart_frame();
    frame_buf[0] = '0;
    fill = 0;
  endfunction

  function automatic wsfr_pkg::result_t frame_fields(wsfr_pkg::status_e st,
                                                     wsfr_pkg::kind_e kind);
    wsfr_pkg::result_t res;
    res.status = st;
    res.kind   = kind;
    res.head   = frame_buf[0];
    res.device = frame_buf[1];
    res.value  = frame_buf[2];
    return res;
  endfunction

  // Advance the mirror by one request and return the result it gives.
  function automatic wsfr_pkg::result_t recognize_frame(logic op, wsfr_pkg::byte_t rx);
    wsfr_pkg::result_t res;
    wsfr_pkg::byte_t   head;
    wsfr_pkg::byte_t   parity;
    wsfr_pkg::byte_t   total;
    res = '0;
    if (op == wsfr_pkg::OP_GAP) begin
      restart_frame();
      return res;
    end

    // Recheck the bytes already held; a broken prefix restarts at position 0
    // and leaves the stale bytes behind it.
    head = frame_buf[0];
    case (fill)
      1: if (!indiv_head(head) && head != wsfr_pkg::HDR_STATUS &&
             head != wsfr_pkg::HDR_ALL && head != id_first) fill = 0;
      2: if (frame_buf[1] != wsfr_pkg::CH_EQ && frame_buf[1] != wsfr_pkg::CH_O &&
             frame_buf[1] != id_second) fill = 0;
      3: if (indiv_head(head)) begin
           if (frame_buf[2] != wsfr_pkg::CH_ZERO && frame_buf[2] != wsfr_pkg::CH_ONE)
             fill = 0;
         end else if (head == wsfr_pkg::HDR_STATUS && frame_buf[2] != wsfr_pkg::CH_L) begin
           fill = 0;
         end
      4: if (indiv_head(head) || head == wsfr_pkg::HDR_ALL) begin
           if (frame_buf[3] != wsfr_pkg::CH_BANG) fill = 0;
         end else if (head == wsfr_pkg::HDR_STATUS && frame_buf[3] != wsfr_pkg::CH_L) begin
           fill = 0;
         end
      5: if (head == wsfr_pkg::HDR_STATUS && frame_buf[4] != wsfr_pkg::CH_BANG) fill = 0;
      default: ;
    endcase

    if (fill >= wsfr_pkg::FRAME_BYTES) fill = 0;
    frame_buf[fill] = rx;
    fill++;

    // The ID header wins over every other kind, even on a stale byte 1.
    head = frame_buf[0];
    if (head == id_first && frame_buf[1] == id_second) begin
      if (fill >= ID_LEN) begin
        parity = '0;
        total  = '0;
        for (int i = 0; i < 7; i++) begin
          if (i < 6) parity ^= frame_buf[i];
          total += frame_buf[i];
        end
        if (parity == frame_buf[6] && total == frame_buf[7]) begin
          res = frame_fields(wsfr_pkg::STATUS_OK, wsfr_pkg::KIND_ID);
        end else begin
          res = frame_fields(wsfr_pkg::STATUS_MISMATCH, wsfr_pkg::KIND_ID);
        end
        restart_frame();
      end
    end else begin
      // Unknown headers pile up until the buffer is full, then drop.
      if (fill >= wsfr_pkg::FRAME_BYTES) restart_frame();
      head = frame_buf[0];
      if (indiv_head(head) || head == wsfr_pkg::HDR_ALL) begin
        if (fill >= CTRL_LEN) begin
          if (frame_buf[4] == wsfr_pkg::CH_CR) begin
            if (indiv_head(head)) res = frame_fields(wsfr_pkg::STATUS_OK, wsfr_pkg::KIND_INDIV);
            else res = frame_fields(wsfr_pkg::STATUS_OK, wsfr_pkg::KIND_ALL);
          end
          restart_frame();
        end
      end else if (head == wsfr_pkg::HDR_STATUS && fill >= STATUS_LEN) begin
        if (frame_buf[5] == wsfr_pkg::CH_CR)
          res = frame_fields(wsfr_pkg::STATUS_OK, wsfr_pkg::KIND_STATUS);
        restart_frame();
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Monitor: track register writes, predict each accepted request, and
  // compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : watch
    wsfr_pkg::result_t want;
    if (rst) begin
      req_taken  = 1'b0;
      block_idle = 1'b0;
      id_first   = '0;
      id_second  = '0;
      fill       = 0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
    end else begin
      req_taken = req.valid && req.ready;
      if (wr_en) begin
        if (wr_index == wsfr_pkg::REG_ID_FIRST) id_first = wr_data;
        else id_second = wr_data;
      end
      if (req_taken) expected_frames.push_back(recognize_frame(req.op, req.rx_byte));
      if (rsp.valid && rsp.ready) begin
        if (expected_frames.size() == 0) begin
          $error("frame result with no request waiting for it");
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_status", want.status, rsp.frame_status);
          check_field("frame_kind", want.kind, rsp.frame_kind);
          check_field("head_byte", want.head, rsp.head_byte);
          check_field("device_byte", want.device, rsp.device_byte);
          check_field("value_byte", want.value, rsp.value_byte);
        end
      end
      block_idle = pending_q.size() == 0 && (!req.valid || req_taken) &&
                   expected_frames.size() == 0;
    end
  end

  // Driver: on the falling edge, advance to the next request once the
  // current one is taken; idle at random unless told to hold busy.
  always @(negedge clk) begin : drive
    request_t next_req;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        next_req = pending_q.pop_front();
        req.valid   <= 1'b1;
        req.op      <= next_req.op;
        req.rx_byte <= next_req.rx_byte;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random unless told to hold busy.
  always @(negedge clk) begin
    rsp.ready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  task automatic push_item(logic op, wsfr_pkg::byte_t b);
    request_t item;
    item.op      = op;
    item.rx_byte = b;
    pending_q.push_back(item);
    queued++;
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(logic idx, wsfr_pkg::byte_t value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Hold until every request is taken and every result has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (!block_idle);
    repeat (2) @(negedge clk);
  endtask

  function automatic wsfr_pkg::byte_t pick_separator();
    wsfr_pkg::byte_t b;
    case ($urandom_range(2))
      0: b = wsfr_pkg::CH_EQ;
      1: b = wsfr_pkg::CH_O;
      default: b = id_second;
    endcase
    return b;
  endfunction

  // Bytes that mostly hit the header and separator checks.
  function automatic wsfr_pkg::byte_t noise_byte();
    wsfr_pkg::byte_t b;
    case ($urandom_range(7))
      0: b = wsfr_pkg::HDR_INDIV_VAL | wsfr_pkg::byte_t'($urandom_range(15));
      1: b = wsfr_pkg::HDR_ALL;
      2: b = wsfr_pkg::HDR_STATUS;
      3: b = $urandom_range(1) ? id_first : id_second;
      4: case ($urandom_range(3))
           0: b = wsfr_pkg::CH_EQ;
           1: b = wsfr_pkg::CH_L;
           2: b = wsfr_pkg::CH_BANG;
           default: b = wsfr_pkg::CH_CR;
         endcase
      default: b = wsfr_pkg::byte_t'($urandom);
    endcase
    return b;
  endfunction

  // Queue a well-formed frame of the given kind, with one byte flipped
  // when spoil_at falls inside it.
  task automatic queue_frame(wsfr_pkg::kind_e kind, int spoil_at);
    wsfr_pkg::byte_t f [$];
    wsfr_pkg::byte_t parity;
    wsfr_pkg::byte_t total;
    case (kind)
      wsfr_pkg::KIND_INDIV: begin
        f.push_back(wsfr_pkg::HDR_INDIV_VAL | wsfr_pkg::byte_t'($urandom_range(15)));
        f.push_back(pick_separator());
        f.push_back($urandom_range(1) ? wsfr_pkg::CH_ONE : wsfr_pkg::CH_ZERO);
        f.push_back(wsfr_pkg::CH_BANG);
        f.push_back(wsfr_pkg::CH_CR);
      end
      wsfr_pkg::KIND_ALL: begin
        f.push_back(wsfr_pkg::HDR_ALL);
        f.push_back(pick_separator());
        f.push_back(wsfr_pkg::byte_t'($urandom));
        f.push_back(wsfr_pkg::CH_BANG);
        f.push_back(wsfr_pkg::CH_CR);
      end
      wsfr_pkg::KIND_STATUS: begin
        f.push_back(wsfr_pkg::HDR_STATUS);
        f.push_back(pick_separator());
        f.push_back(wsfr_pkg::CH_L);
        f.push_back(wsfr_pkg::CH_L);
        f.push_back(wsfr_pkg::CH_BANG);
        f.push_back(wsfr_pkg::CH_CR);
      end
      default: begin
        f.push_back(id_first);
        f.push_back(id_second);
        repeat (4) f.push_back(wsfr_pkg::byte_t'($urandom));
        parity = '0;
        total  = '0;
        foreach (f[i]) begin
          parity ^= f[i];
          total  += f[i];
        end
        f.push_back(parity);
        f.push_back(total + parity);
      end
    endcase
    if (spoil_at >= 0 && spoil_at < f.size())
      f[spoil_at] ^= wsfr_pkg::byte_t'($urandom_range(1, 255));
    foreach (f[i]) push_item(wsfr_pkg::OP_BYTE, f[i]);
  endtask

  // One random piece: mostly frames with random content, some of them
  // spoiled, plus lone gaps and runs of noise.
  task automatic random_chunk();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      queue_frame(wsfr_pkg::kind_e'($urandom_range(3)),
                  $urandom_range(3) == 0 ? int'($urandom_range(7)) : INTACT);
    end else if (pick < 80) begin
      push_item(wsfr_pkg::OP_GAP, wsfr_pkg::byte_t'($urandom));
    end else begin
      repeat ($urandom_range(1, 9)) push_item(wsfr_pkg::OP_BYTE, noise_byte());
    end
  endtask

  task automatic run_phase(wsfr_pkg::byte_t first, wsfr_pkg::byte_t second, logic steady,
                           int count);
    write_reg(wsfr_pkg::REG_ID_FIRST, first);
    write_reg(wsfr_pkg::REG_ID_SECOND, second);
    no_idle <= steady;
    queued = 0;
    while (queued < count) random_chunk();
    wait_drained();
  endtask

  initial begin
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.op      = wsfr_pkg::OP_BYTE;
    req.rx_byte = '0;
    rsp.ready   = 1'b0;
    wr_en       = 1'b0;
    wr_index    = wsfr_pkg::REG_ID_FIRST;
    wr_data     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one frame of each kind, a bad terminator, a checksum
    // mismatch, a gap in the middle of a frame and a zero byte.
    write_reg(wsfr_pkg::REG_ID_FIRST, 8'hA5);
    write_reg(wsfr_pkg::REG_ID_SECOND, 8'h5A);
    queue_frame(wsfr_pkg::KIND_INDIV, INTACT);
    queue_frame(wsfr_pkg::KIND_ALL, 4);
    queue_frame(wsfr_pkg::KIND_STATUS, INTACT);
    queue_frame(wsfr_pkg::KIND_ID, 7);
    push_item(wsfr_pkg::OP_BYTE, wsfr_pkg::HDR_STATUS);
    push_item(wsfr_pkg::OP_GAP, 8'hFF);
    push_item(wsfr_pkg::OP_BYTE, 8'h00);
    wait_drained();

    // Random phases over several header pairs: both extremes, a pair that
    // shadows all-control frames, one inside the individual range, and one
    // on the status header. The third phase runs with no idling at all.
    run_phase(8'hA5, 8'h5A, 1'b0, 155);
    run_phase(8'h00, 8'h00, 1'b0, 155);
    run_phase(8'hFF, 8'hFF, 1'b1, 155);
    run_phase(wsfr_pkg::HDR_ALL, wsfr_pkg::CH_EQ, 1'b0, 155);
    run_phase(8'h34, wsfr_pkg::CH_O, 1'b0, 155);
    run_phase(wsfr_pkg::HDR_STATUS, wsfr_pkg::CH_EQ, 1'b0, 155);

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_wall_switch_frame_recognizer_unit OK");
    end else begin
      $display("tb_wall_switch_frame_recognizer_unit NOT OK");
    end
    $finish;
  end

  // Drop the run if it hangs.
  initial begin
    #2000000;
    $display("tb_wall_switch_frame_recognizer_unit NOT OK");
    $finish;
  end

endmodule
